// ===== rtl/pbfb_pkg.sv =====
`default_nettype none
package pbfb_pkg;

	localparam int BYTE_BITS = 8;
	localparam logic [7:0] BYTE_ONES = 8'd255;

	localparam logic [3:0] CMD_PAGE_USED       = 4'd0;
	localparam logic [3:0] CMD_PAGE_FREE       = 4'd1;
	localparam logic [3:0] CMD_SET_BLOCK       = 4'd2;
	localparam logic [3:0] CMD_CLR_BLOCK       = 4'd3;
	localparam logic [3:0] CMD_OR_MASK         = 4'd4;
	localparam logic [3:0] CMD_CLR_MASK        = 4'd5;
	localparam logic [3:0] CMD_PAGE_QUERY      = 4'd6;
	localparam logic [3:0] CMD_BLOCK_QUERY     = 4'd7;
	localparam logic [3:0] CMD_PAGE_FREE_BYTES = 4'd8;
	localparam logic [3:0] CMD_TOTAL_FREE      = 4'd9;

	localparam logic [1:0] CFG_TRACKED_PAGES = 2'd0;
	localparam logic [1:0] CFG_FILE_PAGES    = 2'd1;
	localparam logic [1:0] CFG_BLOCK_BYTES   = 2'd2;

	localparam logic [15:0] BLOCK_BYTES_RESET = 16'd512;

	// free count pipeline: read, byte count, zero count, product
	localparam logic [1:0] DRAIN_LAST = 2'd3;

	typedef struct packed {
		logic clr_wr;
		logic rd_en;
		logic rd_walk;
		logic rmw;
		logic load;
		logic sum_clr;
		logic out_load;
	} pbfb_cmd_t;

	typedef struct packed {
		logic total;
		logic single;
	} pbfb_stat_t;

	function automatic logic [3:0] popcount8(input logic [7:0] b);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < BYTE_BITS; i++) begin
			n = n + {3'b0, b[i]};
		end
		return n;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/pbfb_ctrl.sv =====
`default_nettype none
module pbfb_ctrl #(
	parameter int ENTRIES = 1024,
	localparam int CNT_W = $clog2(ENTRIES + 1),
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire                      out_ready,
	output logic                     out_valid,
	input  wire pbfb_pkg::pbfb_stat_t stat,
	input  wire [CNT_W-1:0]          lim,
	output pbfb_pkg::pbfb_cmd_t      cmd,
	output logic [AW-1:0]            walk_addr
);

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_DEC   = 3'd2;
	localparam logic [2:0] S_SUM   = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [1:0]       drain_q, drain_d;
	logic             out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		cnt_d = cnt_q;
		drain_d = drain_q;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (cnt_q == CNT_W'(ENTRIES - 1)) begin
					state_d = S_IDLE;
					cnt_d = '0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					cmd.sum_clr = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				cnt_d = '0;
				drain_d = '0;
				if (stat.total) begin
					state_d = S_SUM;
				end else begin
					cmd.rd_en = stat.single;
					state_d = S_DRAIN;
				end
			end
			S_SUM: begin
				cmd.rd_walk = 1'b1;
				cmd.rd_en = (cnt_q < lim);
				cnt_d = cnt_q + 1'b1;
				if (({1'b0, cnt_q} + 1'b1) >= {1'b0, lim}) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				cmd.rmw = (drain_q == 2'd0) && stat.single;
				drain_d = drain_q + 1'b1;
				if (drain_q == pbfb_pkg::DRAIN_LAST) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			cnt_q <= '0;
			drain_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			drain_q <= drain_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign walk_addr = cnt_q[AW-1:0];

	a_no_rd_during_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clr_wr && (cmd.rd_en || cmd.rmw)))
		else $error("memory access during clearing pass");

	a_accept_to_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DEC))
		else $error("accepted item not decoded");

	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result overwrites pending item");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_en && cmd.rd_walk) |-> (cnt_q < lim))
		else $error("walk beyond limit");

endmodule
`default_nettype wire

// ===== rtl/pbfb_dp.sv =====
`default_nettype none
module pbfb_dp #(
	parameter int ENTRIES = 1024,
	parameter int ENTRY_BYTES = 8,
	localparam int CNT_W = $clog2(ENTRIES + 1),
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      cfg_we,
	input  wire [1:0]                cfg_index,
	input  wire [16:0]               cfg_data,
	input  wire [3:0]                command,
	input  wire [15:0]               page,
	input  wire [5:0]                block,
	input  wire [63:0]               mask,
	input  wire pbfb_pkg::pbfb_cmd_t cmd,
	input  wire [AW-1:0]             walk_addr,
	output pbfb_pkg::pbfb_stat_t     stat,
	output logic [CNT_W-1:0]         lim,
	output logic                     status,
	output logic                     used,
	output logic [31:0]              free_bytes
);

	localparam int WORD_BITS = ENTRY_BYTES * pbfb_pkg::BYTE_BITS;
	localparam int ZW = $clog2(WORD_BITS + 1);
	localparam int PW = ZW + 16;

	logic [10:0] tracked_q;
	logic [16:0] file_q;
	logic [15:0] bbytes_q;

	logic [3:0]  cmd_q;
	logic [15:0] page_q;
	logic [5:0]  block_q;
	logic [63:0] mask_q;
	logic        used_q;

	logic [WORD_BITS-1:0] mem [ENTRIES];
	logic [WORD_BITS-1:0] rdata_s1;
	logic                 rv_s1, v_s2, v_s3, v_s4;
	logic [3:0]           bc_s2 [ENTRY_BYTES];
	logic [ZW-1:0]        zeros_s3;
	logic [PW-1:0]        prod_s4;
	logic [31:0]          sum_q;

	logic                 known, block_ok, res_status;
	logic [16:0]          lim_a, lim_b;
	logic [AW-1:0]        page_addr, rd_addr;
	logic [WORD_BITS-1:0] bit_vec, mask_w, new_word;
	logic [ZW-1:0]        ones;
	logic [32:0]          sum_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracked_q <= '0;
			file_q <= '0;
			bbytes_q <= pbfb_pkg::BLOCK_BYTES_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pbfb_pkg::CFG_TRACKED_PAGES: tracked_q <= cfg_data[10:0];
				pbfb_pkg::CFG_FILE_PAGES:    file_q <= cfg_data;
				pbfb_pkg::CFG_BLOCK_BYTES:   bbytes_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			page_q <= page;
			block_q <= block;
			mask_q <= mask;
		end
	end

	assign known = ({1'b0, page_q} < 17'(ENTRIES)) && ({1'b0, page_q} < {6'b0, tracked_q});
	assign lim_a = ({6'b0, tracked_q} < file_q) ? {6'b0, tracked_q} : file_q;
	assign lim_b = (lim_a < 17'(ENTRIES)) ? lim_a : 17'(ENTRIES);
	assign lim = lim_b[CNT_W-1:0];

	always_comb begin
		stat.total = (cmd_q == pbfb_pkg::CMD_TOTAL_FREE);
		stat.single = (cmd_q <= pbfb_pkg::CMD_PAGE_FREE_BYTES) && known;
	end

	assign res_status = (cmd_q <= pbfb_pkg::CMD_PAGE_FREE_BYTES)
		&& (cmd_q != pbfb_pkg::CMD_PAGE_QUERY) && !known;

	assign page_addr = page_q[AW-1:0];
	assign rd_addr = cmd.rd_walk ? walk_addr : page_addr;
	assign block_ok = ({1'b0, block_q} < 7'(WORD_BITS));
	assign bit_vec = block_ok ? (WORD_BITS'(1) << block_q) : '0;
	assign mask_w = mask_q[WORD_BITS-1:0];

	always_comb begin
		unique case (cmd_q)
			pbfb_pkg::CMD_PAGE_USED: new_word = '1;
			pbfb_pkg::CMD_PAGE_FREE: new_word = '0;
			pbfb_pkg::CMD_SET_BLOCK: new_word = rdata_s1 | bit_vec;
			pbfb_pkg::CMD_CLR_BLOCK: new_word = rdata_s1 & ~bit_vec;
			pbfb_pkg::CMD_OR_MASK:   new_word = rdata_s1 | mask_w;
			pbfb_pkg::CMD_CLR_MASK:  new_word = rdata_s1 & ~mask_w;
			default:                 new_word = rdata_s1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			mem[walk_addr] <= '0;
		end else if (cmd.rmw) begin
			mem[page_addr] <= new_word;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			rv_s1 <= cmd.rd_en;
			v_s2 <= rv_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		ones = '0;
		for (int i = 0; i < ENTRY_BYTES; i++) begin
			ones = ones + ZW'(bc_s2[i]);
		end
	end

	assign sum_next = {1'b0, sum_q} + 33'(prod_s4);

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRY_BYTES; i++) begin
			bc_s2[i] <= pbfb_pkg::popcount8(rdata_s1[i*pbfb_pkg::BYTE_BITS +: pbfb_pkg::BYTE_BITS]);
		end
		zeros_s3 <= ZW'(WORD_BITS) - ones;
		prod_s4 <= PW'(zeros_s3) * PW'(bbytes_q);
		if (cmd.sum_clr) begin
			sum_q <= '0;
		end else if (v_s4) begin
			sum_q <= sum_next[32] ? '1 : sum_next[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			used_q <= 1'b0;
		end else if (cmd.rmw) begin
			if (cmd_q == pbfb_pkg::CMD_PAGE_QUERY) begin
				used_q <= |rdata_s1;
			end else if (cmd_q == pbfb_pkg::CMD_BLOCK_QUERY) begin
				used_q <= |(rdata_s1 & bit_vec);
			end else begin
				used_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status <= res_status;
			used <= used_q;
			free_bytes <= ((cmd_q == pbfb_pkg::CMD_PAGE_FREE_BYTES)
				|| (cmd_q == pbfb_pkg::CMD_TOTAL_FREE)) ? sum_q : 32'd0;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/page_block_free_bitmap_unit.sv =====
`default_nettype none
// An item is accepted in idle and decoded; a total free query then walks N words,
// N = min(tracked_pages, file_pages, ENTRIES), one word read a cycle. Each item then
// drains the free count pipeline; no new item is taken until it is done, but the next is
// taken while a result waits, and a result stalls until the previous one is taken.
// Reset: asynchronous, active low; a clearing pass over all ENTRIES words then zeroes
// the bitmap with in_ready low. Configuration writes are taken throughout.
module page_block_free_bitmap_unit #(
	parameter int ENTRIES = 1024,
	parameter int ENTRY_BYTES = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire [1:0]   cfg_index,
	input  wire [16:0]  cfg_data,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire [3:0]   command,
	input  wire [15:0]  page,
	input  wire [5:0]   block,
	input  wire [63:0]  mask,
	output logic        out_valid,
	input  wire         out_ready,
	output logic        status,
	output logic        used,
	output logic [31:0] free_bytes
);

	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	pbfb_pkg::pbfb_cmd_t  cmd;
	pbfb_pkg::pbfb_stat_t stat;
	logic [CNT_W-1:0]     lim;
	logic [AW-1:0]        walk_addr;

	pbfb_ctrl #(
		.ENTRIES(ENTRIES)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.stat(stat),
		.lim(lim),
		.cmd(cmd),
		.walk_addr(walk_addr)
	);

	pbfb_dp #(
		.ENTRIES(ENTRIES),
		.ENTRY_BYTES(ENTRY_BYTES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.command(command),
		.page(page),
		.block(block),
		.mask(mask),
		.cmd(cmd),
		.walk_addr(walk_addr),
		.stat(stat),
		.lim(lim),
		.status(status),
		.used(used),
		.free_bytes(free_bytes)
	);

endmodule
`default_nettype wire
